/* hdl/cct_pkg.sv */
package cct_pkg;

   localparam int DEF_MAX_PARENTS  = 4;
   localparam int DEF_VALUE_LEVELS = 16;
   localparam int DEF_TABLE_ROWS   = 256;
   localparam int DEF_COUNT_BITS   = 32;

   localparam int PARENT_FIELDS = 4;
   localparam int VALUE_W       = 5;
   localparam int COL_W         = 5;
   localparam int ROW_W         = 8;
   localparam int STRIDE_W      = 8;
   localparam int PCOUNT_W      = 3;
   // stride (8 bits) times a value of at most 15, summed over four parents
   localparam int ROW_SUM_W     = 14;
   localparam int RSP_COUNT_W   = 32;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 8;

   localparam logic CMD_COUNT = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_PARENT_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_STRIDE_0     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_STRIDE_1     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_STRIDE_2     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_STRIDE_3     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MISSING_SLOT = 3'd5;

   typedef enum logic [1:0] {
      SKIP_NONE    = 2'd0,
      SKIP_PARENT  = 2'd1,
      SKIP_RANGE   = 2'd2,
      SKIP_NO_SLOT = 2'd3
   } skip_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

endpackage

/* hdl/conditional_count_table.sv */
// Contingency table counter for one node of a discrete network.
// Request channel (req_valid/req_stall): a count word carries the node value
// and up to four parent values (-1 = missing); a read word carries a row and
// a column. Each request word gives exactly one response word on the rsp_
// channel (rsp_valid/rsp_stall): the cell count after the update or on read,
// a counted flag, a skip reason and the cell's row and column.
// The user must write the configuration (csr_write, csr_index, csr_data) only
// while idle; the block itself does not enforce this.
// Each word is registered on acceptance; the count memory is read in LOOKUP
// and written back in UPDATE, and the block holds one word at a time, so
// accesses to a cell never overlap; a new request is taken only in IDLE.
// Reset: the configuration returns to its defaults and a clearing pass
// zeroes the count memory, TABLE_ROWS*(VALUE_LEVELS+1) cells (4352 at the
// defaults), one cell a cycle; req_stall stays high until it ends.
// A stalled response word holds; a finished update then waits in place with
// req_stall high until the response register frees up.
module conditional_count_table #(
   parameter int MAX_PARENTS  = cct_pkg::DEF_MAX_PARENTS,
   parameter int VALUE_LEVELS = cct_pkg::DEF_VALUE_LEVELS,
   parameter int TABLE_ROWS   = cct_pkg::DEF_TABLE_ROWS,
   parameter int COUNT_BITS   = cct_pkg::DEF_COUNT_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [cct_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cct_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic signed [cct_pkg::VALUE_W-1:0]  req_node_value,
   input  logic signed [cct_pkg::VALUE_W-1:0]  req_parent_value_0,
   input  logic signed [cct_pkg::VALUE_W-1:0]  req_parent_value_1,
   input  logic signed [cct_pkg::VALUE_W-1:0]  req_parent_value_2,
   input  logic signed [cct_pkg::VALUE_W-1:0]  req_parent_value_3,
   input  logic [cct_pkg::COL_W-1:0]           req_read_column,
   input  logic [cct_pkg::ROW_W-1:0]           req_read_row,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cct_pkg::RSP_COUNT_W-1:0]     rsp_cell_count,
   output logic                                rsp_was_counted,
   output logic [1:0]                          rsp_skip_reason,
   output logic [cct_pkg::ROW_W-1:0]           rsp_cell_row,
   output logic [cct_pkg::COL_W-1:0]           rsp_cell_column
);

   localparam int COLS  = VALUE_LEVELS + 1;
   localparam int DEPTH = TABLE_ROWS * COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam int PF = cct_pkg::PARENT_FIELDS;
   localparam int SW = cct_pkg::ROW_SUM_W;
   localparam int CW = cct_pkg::COL_W;

   // configuration
   logic [cct_pkg::PCOUNT_W-1:0] parent_count_ff;
   logic [cct_pkg::STRIDE_W-1:0] stride_ff [PF];
   logic                         missing_slot_ff;

   // control
   cct_pkg::state_type state_ff, state_in;
   logic [AW-1:0]      clear_addr_ff, clear_addr_in;

   // word in flight
   logic               cmd_ff, cmd_in;
   cct_pkg::skip_type  reason_ff, reason_in;
   logic [SW-1:0]      row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;

   // memory
   logic [COUNT_BITS-1:0] cnt_mem_ff [DEPTH];
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic [AW-1:0]         addr;
   logic [AW-1:0]         wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic [COUNT_BITS-1:0] cnt_next;
   logic                  mem_we;

   // response register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [cct_pkg::RSP_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                            rsp_counted_ff, rsp_counted_in;
   cct_pkg::skip_type               rsp_reason_ff, rsp_reason_in;
   logic [cct_pkg::ROW_W-1:0]       rsp_row_ff, rsp_row_in;
   logic [CW-1:0]                   rsp_col_ff, rsp_col_in;

   logic accept;
   logic rsp_free;
   logic load_rsp;
   logic count_hit;

   logic signed [cct_pkg::VALUE_W-1:0] pval [PF];

   assign pval[0] = req_parent_value_0;
   assign pval[1] = req_parent_value_1;
   assign pval[2] = req_parent_value_2;
   assign pval[3] = req_parent_value_3;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         parent_count_ff <= '0;
         stride_ff[0]    <= cct_pkg::STRIDE_W'(1);
         stride_ff[1]    <= '0;
         stride_ff[2]    <= '0;
         stride_ff[3]    <= '0;
         missing_slot_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            cct_pkg::REG_PARENT_COUNT: parent_count_ff <= csr_data[cct_pkg::PCOUNT_W-1:0];
            cct_pkg::REG_STRIDE_0:     stride_ff[0]    <= csr_data;
            cct_pkg::REG_STRIDE_1:     stride_ff[1]    <= csr_data;
            cct_pkg::REG_STRIDE_2:     stride_ff[2]    <= csr_data;
            cct_pkg::REG_STRIDE_3:     stride_ff[3]    <= csr_data;
            cct_pkg::REG_MISSING_SLOT: missing_slot_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // ---------------- request decode ----------------
   always_comb begin
      logic          par_missing;
      logic          bad_range;
      logic          in_use;
      logic [SW-1:0] row_sum;
      logic          node_missing;
      par_missing  = 1'b0;
      bad_range    = 1'b0;
      row_sum      = '0;
      in_use       = 1'b0;
      node_missing = (req_node_value == -5'sd1);
      for (int i = 0; i < PF; i++) begin
         in_use = (32'(parent_count_ff) > i) && (MAX_PARENTS > i);
         if (in_use) begin
            if (pval[i] == -5'sd1) begin
               par_missing = 1'b1;
            end else if (pval[i][cct_pkg::VALUE_W-1]
                         || (32'(pval[i][cct_pkg::VALUE_W-2:0]) >= 32'(VALUE_LEVELS))) begin
               bad_range = 1'b1;
            end else begin
               row_sum = row_sum + SW'(SW'(stride_ff[i])
                                       * SW'(pval[i][cct_pkg::VALUE_W-2:0]));
            end
         end
      end
      if (!node_missing && (req_node_value[cct_pkg::VALUE_W-1]
          || (32'(req_node_value[cct_pkg::VALUE_W-2:0]) >= 32'(VALUE_LEVELS)))) begin
         bad_range = 1'b1;
      end
      if (32'(row_sum) >= 32'(TABLE_ROWS)) begin
         bad_range = 1'b1;
      end

      cmd_in = req_command;
      if (req_command == cct_pkg::CMD_READ) begin
         row_in = SW'(req_read_row);
         col_in = req_read_column;
         if ((32'(req_read_row) >= 32'(TABLE_ROWS)) || (32'(req_read_column) >= 32'(COLS))) begin
            reason_in = cct_pkg::SKIP_RANGE;
         end else begin
            reason_in = cct_pkg::SKIP_NONE;
         end
      end else begin
         row_in = row_sum;
         col_in = node_missing ? '0
                  : CW'(req_node_value[cct_pkg::VALUE_W-2:0]) + CW'(missing_slot_ff);
         if (par_missing) begin
            reason_in = cct_pkg::SKIP_PARENT;
         end else if (node_missing && !missing_slot_ff) begin
            reason_in = cct_pkg::SKIP_NO_SLOT;
         end else if (bad_range) begin
            reason_in = cct_pkg::SKIP_RANGE;
         end else begin
            reason_in = cct_pkg::SKIP_NONE;
         end
         // skipped samples report row and column as zero
         if (reason_in != cct_pkg::SKIP_NONE) begin
            row_in = '0;
            col_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= cmd_in;
         reason_ff <= reason_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
      end
   end

   // ---------------- state machine ----------------
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cct_pkg::ST_CLEAR:  if (clear_addr_ff == AW'(DEPTH - 1)) state_in = cct_pkg::ST_IDLE;
         cct_pkg::ST_IDLE:   if (req_valid) state_in = cct_pkg::ST_LOOKUP;
         cct_pkg::ST_LOOKUP: state_in = cct_pkg::ST_UPDATE;
         cct_pkg::ST_UPDATE: if (rsp_free) state_in = cct_pkg::ST_IDLE;
         default:            state_in = cct_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      load_rsp  = 1'b0;
      unique case (state_ff)
         cct_pkg::ST_CLEAR:  ;
         cct_pkg::ST_IDLE:   req_stall = 1'b0;
         cct_pkg::ST_LOOKUP: ;
         cct_pkg::ST_UPDATE: load_rsp = rsp_free;
         default:            ;
      endcase
   end

   assign clear_addr_in = (state_ff == cct_pkg::ST_CLEAR) ? clear_addr_ff + AW'(1) : clear_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cct_pkg::ST_CLEAR;
         clear_addr_ff <= '0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   // ---------------- count memory ----------------
   // out-of-range cells never touch the memory; park the address at zero
   assign addr = (reason_ff == cct_pkg::SKIP_NONE)
                 ? AW'(AW'(row_ff) * AW'(COLS) + AW'(col_ff)) : '0;

   assign cnt_next  = (&rd_data_ff) ? rd_data_ff : rd_data_ff + COUNT_BITS'(1);
   assign count_hit = (cmd_ff == cct_pkg::CMD_COUNT) && (reason_ff == cct_pkg::SKIP_NONE);

   always_comb begin
      if (state_ff == cct_pkg::ST_CLEAR) begin
         mem_we  = 1'b1;
         wr_addr = clear_addr_ff;
         wr_data = '0;
      end else begin
         mem_we  = load_rsp && count_hit;
         wr_addr = addr;
         wr_data = cnt_next;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cnt_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= cnt_mem_ff[addr];
   end

   // ---------------- response register ----------------
   always_comb begin
      rsp_valid_in   = load_rsp || (rsp_valid_ff && rsp_stall);
      rsp_reason_in  = reason_ff;
      rsp_row_in     = row_ff[cct_pkg::ROW_W-1:0];
      rsp_col_in     = col_ff;
      rsp_counted_in = count_hit;
      if (reason_ff != cct_pkg::SKIP_NONE) begin
         rsp_count_in = '0;
      end else if (count_hit) begin
         rsp_count_in = cct_pkg::RSP_COUNT_W'(cnt_next);
      end else begin
         rsp_count_in = cct_pkg::RSP_COUNT_W'(rd_data_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_count_ff   <= rsp_count_in;
         rsp_counted_ff <= rsp_counted_in;
         rsp_reason_ff  <= rsp_reason_in;
         rsp_row_ff     <= rsp_row_in;
         rsp_col_ff     <= rsp_col_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_count  = rsp_count_ff;
   assign rsp_was_counted = rsp_counted_ff;
   assign rsp_skip_reason = rsp_reason_ff;
   assign rsp_cell_row    = rsp_row_ff;
   assign rsp_cell_column = rsp_col_ff;

endmodule
